// ----- rtl/slsch_pkg.sv -----
package slsch_pkg;

    localparam int MAX_JOBS_DEF  = 64;
    localparam int TIME_BITS_DEF = 16;

    // port widths fixed by the word format
    localparam int FIELD_W = 16;
    localparam int OUT_W   = 23;
    localparam logic [OUT_W-1:0] OUT_MAX = {OUT_W{1'b1}};

    // control from the sequencer to the selection unit
    typedef struct packed {
        logic clear;   // start a fresh pass
        logic take;    // a store entry is on the read bus
    } sel_ctrl_t;

endpackage

// ----- rtl/slsch_job_ram.sv -----
module slsch_job_ram #(
    parameter int DEPTH = slsch_pkg::MAX_JOBS_DEF,
    parameter int AW    = 6,
    parameter int DW    = 49
) (
    input  logic          clk,
    input  logic          wr_en,
    input  logic [AW-1:0] wr_addr,
    input  logic [DW-1:0] wr_data,
    input  logic          rd_en,
    input  logic [AW-1:0] rd_addr,
    output logic [DW-1:0] rd_data
);

    logic [DW-1:0] mem [DEPTH];
    logic [DW-1:0] rd_data_reg;

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[wr_addr] <= wr_data;
        end
        if (rd_en)
        begin
            rd_data_reg <= mem[rd_addr];
        end
    end

    assign rd_data = rd_data_reg;

endmodule

// ----- rtl/slsch_sel.sv -----
module slsch_sel #(
    parameter int TIME_BITS = slsch_pkg::TIME_BITS_DEF,
    parameter int AW        = 6,
    parameter int TW        = 23
) (
    input  logic                  clk,
    input  logic                  rst_n,
    input  slsch_pkg::sel_ctrl_t  ctrl,
    input  logic [TIME_BITS-1:0]  ent_rel,
    input  logic [TIME_BITS-1:0]  ent_proc,
    input  logic [TIME_BITS-1:0]  ent_tail,
    input  logic                  ent_mark,
    input  logic [AW-1:0]         ent_idx,
    input  logic [TW-1:0]         cur_time,
    output logic                  found,
    output logic [TIME_BITS-1:0]  min_rel,
    output logic [AW-1:0]         pick_idx,
    output logic [TIME_BITS-1:0]  pick_rel,
    output logic [TIME_BITS-1:0]  pick_proc,
    output logic [TIME_BITS-1:0]  pick_tail
);

    logic                 found_reg;
    logic [TIME_BITS-1:0] min_rel_reg;
    logic [AW-1:0]        pick_idx_reg;
    logic [TIME_BITS-1:0] pick_rel_reg;
    logic [TIME_BITS-1:0] pick_proc_reg;
    logic [TIME_BITS-1:0] pick_tail_reg;
    logic                 live;
    logic                 better;

    assign live   = ctrl.take && !ent_mark;
    // strict compare keeps the earliest loaded job on equal tails
    assign better = live && (TW'(ent_rel) <= cur_time)
                    && (!found_reg || (ent_tail > pick_tail_reg));

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            found_reg <= 1'b0;
        end
        else if (ctrl.clear)
        begin
            found_reg <= 1'b0;
        end
        else if (better)
        begin
            found_reg <= 1'b1;
        end
    end

    always_ff @(posedge clk)
    begin
        if (ctrl.clear)
        begin
            min_rel_reg <= '1;
        end
        else
        begin
            if (live && (ent_rel < min_rel_reg))
            begin
                min_rel_reg <= ent_rel;
            end
            if (better)
            begin
                pick_idx_reg  <= ent_idx;
                pick_rel_reg  <= ent_rel;
                pick_proc_reg <= ent_proc;
                pick_tail_reg <= ent_tail;
            end
        end
    end

    assign found     = found_reg;
    assign min_rel   = min_rel_reg;
    assign pick_idx  = pick_idx_reg;
    assign pick_rel  = pick_rel_reg;
    assign pick_proc = pick_proc_reg;
    assign pick_tail = pick_tail_reg;

endmodule

// ----- rtl/schrage_list_scheduler.sv -----
// Schrage list scheduler, one machine, release/processing/tail per job.
// Input channel: one job per word (release_time, processing_time,
// tail_time, last_job), accepted when in_valid is high and in_stall low.
// Jobs load at one word per cycle while in_stall is low; beyond MAX_JOBS they
// are dropped and jobs_dropped is raised on that set's result.
// The word with last_job set closes the set and starts the schedule.
// in_stall stays high until the result has been placed in the output
// register. Each selection pass reads the n stored jobs through the single
// read port of the job store. A pass that finds nothing ready only moves
// time on, to the earliest release still waiting.
// Output channel: one word (max_completion, jobs_dropped) per set, held in
// a register until taken. While it waits behind out_stall, new jobs are
// still loaded; a following set finishing its schedule waits for the
// register to free before it is written.
// Reset (rst_n low) empties the store count, drops any pending result and
// returns to loading.
module schrage_list_scheduler #(
    parameter int MAX_JOBS  = slsch_pkg::MAX_JOBS_DEF,
    parameter int TIME_BITS = slsch_pkg::TIME_BITS_DEF
) (
    input  logic                              clk,
    input  logic                              rst_n,
    input  logic                              in_valid,
    output logic                              in_stall,
    input  logic [slsch_pkg::FIELD_W-1:0]     release_time,
    input  logic [slsch_pkg::FIELD_W-1:0]     processing_time,
    input  logic [slsch_pkg::FIELD_W-1:0]     tail_time,
    input  logic                              last_job,
    output logic                              out_valid,
    input  logic                              out_stall,
    output logic [slsch_pkg::OUT_W-1:0]       max_completion,
    output logic                              jobs_dropped
);

    localparam int AW   = (MAX_JOBS > 1) ? $clog2(MAX_JOBS) : 1;
    localparam int CNTW = $clog2(MAX_JOBS + 1);
    localparam int TW   = TIME_BITS + $clog2(MAX_JOBS + 2);
    localparam int DW   = 3 * TIME_BITS + 1;
    localparam int CW   = (TW > slsch_pkg::OUT_W) ? TW : slsch_pkg::OUT_W;

    typedef enum logic [4:0] {
        ST_LOAD = 5'b00001,
        ST_SCAN = 5'b00010,
        ST_PICK = 5'b00100,
        ST_UPD  = 5'b01000,
        ST_EMIT = 5'b10000
    } state_t;

    state_t                       state_reg, state_next;
    logic [CNTW-1:0]              count_reg;
    logic                         overflow_reg;
    logic [CNTW-1:0]              left_reg;
    logic [CNTW-1:0]              rd_idx_reg;
    logic                         dv_reg;
    logic [AW-1:0]                didx_reg;
    logic [TW-1:0]                time_reg;
    logic [TW-1:0]                best_reg;
    logic                         out_valid_reg;
    logic [slsch_pkg::OUT_W-1:0]  out_max_reg;
    logic                         out_drop_reg;

    logic                         in_acc;
    logic                         room;
    logic                         wr_en;
    logic [AW-1:0]                wr_addr;
    logic [DW-1:0]                wr_data;
    logic                         rd_en;
    logic [DW-1:0]                rd_data;
    logic                         last_data;
    slsch_pkg::sel_ctrl_t         sel_ctrl;
    logic                         found;
    logic [TIME_BITS-1:0]         min_rel;
    logic [AW-1:0]                pick_idx;
    logic [TIME_BITS-1:0]         pick_rel;
    logic [TIME_BITS-1:0]         pick_proc;
    logic [TIME_BITS-1:0]         pick_tail;
    logic [TW-1:0]                cand;
    logic [CW-1:0]                best_ext;
    logic [slsch_pkg::OUT_W-1:0]  best_sat;

    assign in_stall = (state_reg != ST_LOAD);
    assign in_acc   = in_valid && !in_stall;
    assign room     = (count_reg < CNTW'(MAX_JOBS));

    // store entry: {scheduled, tail, proc, rel}
    always_comb
    begin
        wr_en   = 1'b0;
        wr_addr = count_reg[AW-1:0];
        wr_data = {1'b0, TIME_BITS'(tail_time), TIME_BITS'(processing_time),
                   TIME_BITS'(release_time)};
        if (state_reg == ST_PICK)
        begin
            wr_en   = found;
            wr_addr = pick_idx;
            wr_data = {1'b1, pick_tail, pick_proc, pick_rel};
        end
        else if (in_acc && room)
        begin
            wr_en = 1'b1;
        end
    end

    assign rd_en     = (state_reg == ST_SCAN) && (rd_idx_reg < count_reg);
    assign last_data = dv_reg && (CNTW'(didx_reg) == (count_reg - CNTW'(1)));

    slsch_job_ram #(
        .DEPTH (MAX_JOBS),
        .AW    (AW),
        .DW    (DW)
    ) u_ram (
        .clk     (clk),
        .wr_en   (wr_en),
        .wr_addr (wr_addr),
        .wr_data (wr_data),
        .rd_en   (rd_en),
        .rd_addr (rd_idx_reg[AW-1:0]),
        .rd_data (rd_data)
    );

    assign sel_ctrl.clear = (state_reg == ST_UPD) || in_acc;
    assign sel_ctrl.take  = dv_reg;

    slsch_sel #(
        .TIME_BITS (TIME_BITS),
        .AW        (AW),
        .TW        (TW)
    ) u_sel (
        .clk       (clk),
        .rst_n     (rst_n),
        .ctrl      (sel_ctrl),
        .ent_rel   (rd_data[TIME_BITS-1:0]),
        .ent_proc  (rd_data[2*TIME_BITS-1:TIME_BITS]),
        .ent_tail  (rd_data[3*TIME_BITS-1:2*TIME_BITS]),
        .ent_mark  (rd_data[DW-1]),
        .ent_idx   (didx_reg),
        .cur_time  (time_reg),
        .found     (found),
        .min_rel   (min_rel),
        .pick_idx  (pick_idx),
        .pick_rel  (pick_rel),
        .pick_proc (pick_proc),
        .pick_tail (pick_tail)
    );

    assign cand     = time_reg + TW'(pick_tail);
    assign best_ext = CW'(best_reg);
    assign best_sat = (best_ext > CW'(slsch_pkg::OUT_MAX)) ? slsch_pkg::OUT_MAX
                                                          : best_ext[slsch_pkg::OUT_W-1:0];

    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            ST_LOAD:
            begin
                if (in_acc && last_job)
                begin
                    state_next = ST_SCAN;
                end
            end
            ST_SCAN:
            begin
                if (last_data)
                begin
                    state_next = ST_PICK;
                end
            end
            ST_PICK:
            begin
                state_next = ST_UPD;
            end
            ST_UPD:
            begin
                state_next = (left_reg == '0) ? ST_EMIT : ST_SCAN;
            end
            ST_EMIT:
            begin
                if (!out_valid_reg)
                begin
                    state_next = ST_LOAD;
                end
            end
            default:
            begin
                state_next = ST_LOAD;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_LOAD;
            count_reg     <= '0;
            overflow_reg  <= 1'b0;
            left_reg      <= '0;
            rd_idx_reg    <= '0;
            dv_reg        <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            dv_reg    <= rd_en;
            if (rd_en)
            begin
                rd_idx_reg <= rd_idx_reg + CNTW'(1);
            end
            if (in_acc)
            begin
                rd_idx_reg <= '0;
                if (room)
                begin
                    count_reg <= count_reg + CNTW'(1);
                    left_reg  <= count_reg + CNTW'(1);
                end
                else
                begin
                    overflow_reg <= 1'b1;
                    left_reg     <= count_reg;
                end
            end
            if ((state_reg == ST_PICK) && found)
            begin
                left_reg <= left_reg - CNTW'(1);
            end
            if (state_reg == ST_UPD)
            begin
                rd_idx_reg <= '0;
            end
            if (out_valid_reg && !out_stall)
            begin
                out_valid_reg <= 1'b0;
            end
            if ((state_reg == ST_EMIT) && !out_valid_reg)
            begin
                out_valid_reg <= 1'b1;
                count_reg     <= '0;
                overflow_reg  <= 1'b0;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (dv_reg || rd_en)
        begin
            didx_reg <= rd_idx_reg[AW-1:0];
        end
        if (in_acc)
        begin
            time_reg <= '0;
            best_reg <= '0;
        end
        if (state_reg == ST_PICK)
        begin
            // idle machine jumps to the earliest release still waiting
            time_reg <= found ? (time_reg + TW'(pick_proc)) : TW'(min_rel);
        end
        if ((state_reg == ST_UPD) && found && (cand > best_reg))
        begin
            best_reg <= cand;
        end
        if ((state_reg == ST_EMIT) && !out_valid_reg)
        begin
            out_max_reg  <= best_sat;
            out_drop_reg <= overflow_reg;
        end
    end

    assign out_valid      = out_valid_reg;
    assign max_completion = out_max_reg;
    assign jobs_dropped   = out_drop_reg;

    a_no_write_in_scan: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == ST_SCAN) |-> !wr_en)
        else $error("store written during a selection pass");

    a_left_bounded: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg != ST_LOAD) |-> (left_reg <= count_reg))
        else $error("remaining jobs exceed stored jobs");

    a_count_bounded: assert property (@(posedge clk) disable iff (!rst_n)
        count_reg <= CNTW'(MAX_JOBS))
        else $error("store count beyond capacity");

    a_emit_result: assert property (@(posedge clk) disable iff (!rst_n)
        ((state_reg == ST_EMIT) && !out_valid_reg)
        |=> (out_valid_reg && (state_reg == ST_LOAD) && (count_reg == '0)))
        else $error("result not posted on leaving the schedule");

endmodule
